// ===== design/bsc_pkg.sv =====
package bsc_pkg;

	// Operand and result widths of the shared multiply-divide unit
	localparam int XW = 24;        // raw sample / stored temperature
	localparam int YW = 32;        // coefficient term
	localparam int PW = XW + YW;   // product magnitude
	localparam int KW = 23;        // scaling divisor
	localparam int QW = 40;        // signed quotient

	localparam logic [2:0] REG_COEF_A    = 3'd0;
	localparam logic [2:0] REG_COEF_B    = 3'd1;
	localparam logic [2:0] REG_COEF_C    = 3'd2;
	localparam logic [2:0] REG_TEMP_OSR  = 3'd3;
	localparam logic [2:0] REG_PRESS_OSR = 3'd4;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	localparam logic [15:0] PRESS_REF_LO = 16'(32'd101325);

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [YW-1:0] y;
		logic [KW-1:0]        k;
	} req_t;

	// Scaling divisor for an oversampling code
	function automatic logic [KW-1:0] scale_div(input logic [2:0] code);
		logic [KW-1:0] d;
		case (code)
			3'd0: d = KW'(524288);
			3'd1: d = KW'(1572864);
			3'd2: d = KW'(3670016);
			3'd3: d = KW'(7864320);
			3'd4: d = KW'(253952);
			3'd5: d = KW'(516096);
			3'd6: d = KW'(1040384);
			default: d = KW'(2088960);
		endcase
		return d;
	endfunction

endpackage

// ===== design/bsc_muldiv.sv =====
module bsc_muldiv import bsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  req_t                 req,
	output logic                 done,
	output logic signed [QW-1:0] q
);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_MUL  = 2'd1;
	localparam logic [1:0] U_DIV  = 2'd2;
	localparam logic [1:0] U_FIX  = 2'd3;

	logic [1:0]    st_q;
	logic [5:0]    cnt_q;
	logic [XW-1:0] ax_q;
	logic [YW-1:0] ay_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] rem_q;
	logic [PW-1:0] prod_q;
	logic          neg_q;
	logic          done_q;
	logic signed [QW-1:0] q_q;

	logic [KW:0]   rem_sh;
	logic          div_ge;
	logic [KW:0]   rem_sub;

	always_comb begin
		rem_sh  = {rem_q, prod_q[PW-1]};
		div_ge  = (rem_sh >= {1'b0, k_q});
		rem_sub = rem_sh - {1'b0, k_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
			ax_q   <= '0;
			ay_q   <= '0;
			k_q    <= '0;
			rem_q  <= '0;
			prod_q <= '0;
			neg_q  <= 1'b0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				U_IDLE: begin
					if (start) begin
						// take magnitudes, keep the result sign aside
						ax_q   <= req.x[XW-1] ? (~req.x + 1'b1) : req.x;
						ay_q   <= req.y[YW-1] ? (~req.y + 1'b1) : req.y;
						k_q    <= req.k;
						neg_q  <= req.x[XW-1] ^ req.y[YW-1];
						prod_q <= '0;
						cnt_q  <= 6'(XW - 1);
						st_q   <= U_MUL;
					end
				end
				U_MUL: begin
					prod_q <= {prod_q[PW-2:0], 1'b0} +
						(ax_q[XW-1] ? {{XW{1'b0}}, ay_q} : '0);
					ax_q <= {ax_q[XW-2:0], 1'b0};
					if (cnt_q == '0) begin
						cnt_q <= 6'(PW - 1);
						rem_q <= '0;
						st_q  <= U_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_DIV: begin
					// restoring division, one quotient bit a cycle
					rem_q  <= div_ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
					prod_q <= {prod_q[PW-2:0], div_ge};
					if (cnt_q == '0) begin
						st_q <= U_FIX;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					q_q    <= neg_q ? -$signed(prod_q[QW-1:0]) : $signed(prod_q[QW-1:0]);
					done_q <= 1'b1;
					st_q   <= U_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// ===== design/baro_sensor_compensation_core.sv =====
// Barometric sensor compensation core.
//
// Input stream (s_*): one raw converter reading per item. s_tuser carries
// the kind (0 temperature, 1 pressure), s_tdata the signed 24-bit reading.
// Output stream (m_*): exactly one result per item. m_tuser repeats the
// kind, m_tdata holds the signed 16-bit result: tenths of a degree, or the
// pressure offset from 101325 Pa, wrapping at 16 bits.
// Config channel (cfg_*): always ready; index 0..2 load the calibration
// words, 3 and 4 the oversampling codes, other indexes are dropped.
// Every product and scaled quotient runs through one shared shift-add
// multiplier and restoring divider, one bit a cycle. A temperature item
// needs one term, a pressure item six chained terms. The input is
// accepted only while the sequencer is idle, one item at a time: the next
// item can be taken the cycle after the result is loaded.
// Reset clears the calibration registers, the stored temperature and all
// control state. A stalled receiver holds the result in the output
// register; the next item is still accepted and finishes into that
// register once the receiver takes the earlier result.
module baro_sensor_compensation_core import bsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] raw_sample
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] value
	output logic        m_tuser,   // [0] kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [2:0] STEP_A = 3'd0;
	localparam logic [2:0] STEP_B = 3'd1;
	localparam logic [2:0] STEP_C = 3'd2;
	localparam logic [2:0] STEP_D = 3'd3;
	localparam logic [2:0] STEP_E = 3'd4;
	localparam logic [2:0] STEP_F = 3'd5;

	logic [47:0] coef_a_q, coef_b_q, coef_c_q;
	logic [2:0]  tosr_q, posr_q;
	logic signed [XW-1:0] last_temp_q;
	logic signed [XW-1:0] raw_q;
	logic        op_q;
	logic [1:0]  st_q;
	logic [2:0]  step_q;
	logic        start_q;
	logic signed [QW-1:0] prev_q, c_q;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tuser_q;

	req_t        req;
	logic        done;
	logic signed [QW-1:0] q;
	logic [15:0] res;
	logic        fin_load;

	// Unpack the calibration coefficients
	logic signed [11:0] c0, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;
	logic signed [YW-1:0] c1_x10;

	assign c0  = coef_a_q[47:36];
	assign c1  = coef_a_q[35:24];
	assign c00 = coef_a_q[23:4];
	assign c10 = {coef_a_q[3:0], coef_b_q[47:32]};
	assign c01 = coef_b_q[31:16];
	assign c11 = coef_b_q[15:0];
	assign c20 = coef_c_q[47:32];
	assign c21 = coef_c_q[31:16];
	assign c30 = coef_c_q[15:0];
	assign c1_x10 = (YW'(c1) <<< 3) + (YW'(c1) <<< 1);

	// Operands of the current term; earlier quotients feed the nested form
	always_comb begin
		req.x = raw_q;
		req.y = YW'(c30);
		req.k = scale_div(posr_q);
		if (op_q == OP_TEMP) begin
			req.y = c1_x10;
			req.k = scale_div(tosr_q);
		end else begin
			case (step_q)
				STEP_A: req.y = YW'(c30);
				STEP_B: req.y = YW'(c20) + YW'(prev_q);
				STEP_C: req.y = YW'(c10) + YW'(prev_q);
				STEP_D: req.y = YW'(c21);
				STEP_E: req.y = YW'(c11) + YW'(prev_q);
				default: begin
					req.x = last_temp_q;
					req.y = YW'(c01) + YW'(prev_q);
					req.k = scale_div(tosr_q);
				end
			endcase
		end
	end

	bsc_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req),
		.done   (done),
		.q      (q)
	);

	// Final sums wrap at 16 bits, so only the low bits are kept
	always_comb begin
		if (op_q == OP_TEMP) begin
			res = (16'(c0) << 2) + 16'(c0) + prev_q[15:0];
		end else begin
			res = 16'(c00) + c_q[15:0] + prev_q[15:0] - PRESS_REF_LO;
		end
	end

	// Load the finished result once the output register is free
	assign fin_load = (st_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			tosr_q   <= '0;
			posr_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_A:    coef_a_q <= cfg_data;
				REG_COEF_B:    coef_b_q <= cfg_data;
				REG_COEF_C:    coef_c_q <= cfg_data;
				REG_TEMP_OSR:  tosr_q   <= cfg_data[2:0];
				REG_PRESS_OSR: posr_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= STEP_A;
			start_q     <= 1'b0;
			op_q        <= OP_TEMP;
			raw_q       <= '0;
			last_temp_q <= '0;
			prev_q      <= '0;
			c_q         <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
		end else begin
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						raw_q   <= s_tdata;
						if (s_tuser == OP_TEMP) begin
							last_temp_q <= s_tdata;
						end
						step_q  <= STEP_A;
						start_q <= 1'b1;
						st_q    <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (done) begin
						prev_q <= q;
						if (step_q == STEP_C) begin
							c_q <= q;
						end
						if (op_q == OP_TEMP || step_q == STEP_F) begin
							st_q <= ST_FIN;
						end else begin
							step_q  <= step_q + 1'b1;
							start_q <= 1'b1;
						end
					end else begin
						start_q <= 1'b0;
					end
				end
				ST_FIN: begin
					// hold the result until the output register is free
					if (fin_load) begin
						m_tdata_q  <= res;
						m_tuser_q  <= op_q;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == ST_RUN)
		else $error("unit finished outside a run");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> st_q == ST_RUN && start_q)
		else $error("accepted item did not start the unit");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN && (!m_tvalid || m_tready) |=> m_tvalid && st_q == ST_IDLE)
		else $error("finished result not loaded");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_F)
		else $error("step counter out of range");

endmodule

// ===== tb/sv/baro_sensor_compensation_core_test.sv =====
`timescale 1ns / 100ps

// Compensation core bench: items go in through s_*, each accepted item runs through a
// local compensation model and the expected result is queued; m_* results are
// compared against the oldest queued result. Calibration and oversampling are
// reloaded between phases while the core is idle.
module baro_sensor_compensation_core_test;
	import bsc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic        kind;
		logic [15:0] value;
	} result_t;

	// One row of the directed table: typed marks a row whose result is known outright
	typedef struct {
		logic        op;
		logic [23:0] raw;
		bit          typed;
		logic [15:0] value;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [23:0] raw_sample
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] value
	logic        m_tuser;   // [0] kind
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;

	baro_sensor_compensation_core dut (.*);

	// Model state: calibration words, oversampling codes, stored temperature
	logic [47:0] cal_a, cal_b, cal_c;
	logic [2:0]  t_osr, p_osr;
	logic [23:0] held_temp;

	result_t     pending_results[$];
	stim_row_t   sent_rows[$];
	int          mismatches;
	int          temp_results, press_results, cfg_writes;
	int          cycles;
	bit          no_idle;
	bit          hold_req;
	bit          hold_done;
	int          hold_left;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// Divisor for an oversampling code
	function automatic longint osr_divisor(input logic [2:0] code);
		longint divs[8] = '{524288, 1572864, 3670016, 7864320,
		                    253952, 516096, 1040384, 2088960};
		return divs[code];
	endfunction

	// Compensated value for one item; a temperature item also updates the held sample
	function automatic logic [15:0] compensate(input logic op, input logic [23:0] raw);
		longint x, kt, kp, r, tt;
		longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
		longint a, b, c, d, e, f;
		logic [19:0] c10_bits;
		x  = longint'($signed(raw));
		kt = osr_divisor(t_osr);
		kp = osr_divisor(p_osr);
		if (op == OP_TEMP) begin
			c0 = longint'($signed(cal_a[47:36]));
			c1 = longint'($signed(cal_a[35:24]));
			held_temp = raw;
			r = c0 * 5 + (c1 * x * 10) / kt;
		end else begin
			c10_bits = {cal_a[3:0], cal_b[47:32]};
			c00 = longint'($signed(cal_a[23:4]));
			c10 = longint'($signed(c10_bits));
			c01 = longint'($signed(cal_b[31:16]));
			c11 = longint'($signed(cal_b[15:0]));
			c20 = longint'($signed(cal_c[47:32]));
			c21 = longint'($signed(cal_c[31:16]));
			c30 = longint'($signed(cal_c[15:0]));
			tt  = longint'($signed(held_temp));
			a = (x * c30) / kp;
			b = (x * (c20 + a)) / kp;
			c = (x * (c10 + b)) / kp;
			d = (x * c21) / kp;
			e = (x * (c11 + d)) / kp;
			f = (tt * (c01 + e)) / kt;
			r = c00 + c + f - 101325;
		end
		return r[15:0];
	endfunction

	// Predict on every accepted item; typed rows override the model's figure
	always @(posedge clk) begin
		stim_row_t row;
		result_t   res;
		logic [15:0] v;
		if (arst_n && s_tvalid && s_tready) begin
			row = sent_rows.pop_front();
			v = compensate(s_tuser, s_tdata);
			res.kind  = s_tuser;
			res.value = row.typed ? row.value : v;
			pending_results.push_back(res);
		end
	end

	// Check every result against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d value %h", m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser == OP_TEMP) temp_results++; else press_results++;
				if (m_tuser !== want.kind || m_tdata !== want.value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d value %h, got kind %0d value %h",
							want.kind, want.value, m_tuser, m_tdata);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the core backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 30);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one item; valid stays high on return so back-to-back items never drop it
	task automatic offer_item(input logic op, input logic [23:0] raw, input bit typed,
	                          input logic [15:0] value);
		stim_row_t row;
		row.op = op; row.raw = raw; row.typed = typed; row.value = value;
		if (!no_idle && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		sent_rows.push_back(row);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
	endtask

	// Write one register; valid stays high on return, the caller drops it after a run
	// of writes. The model follows, dropping excess bits and unknown indexes
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
		case (idx)
			REG_COEF_A:    cal_a = data;
			REG_COEF_B:    cal_b = data;
			REG_COEF_C:    cal_c = data;
			REG_TEMP_OSR:  t_osr = data[2:0];
			REG_PRESS_OSR: p_osr = data[2:0];
			default: ;
		endcase
	endtask

	// Drop valid and wait until every result is in and the core has gone quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_raw();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(0, 2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pick_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 48'h7FF7FF7FFFF7;
			3: return 48'h800800800008;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	stim_row_t reset_rows[] = '{
		'{OP_PRESS, 24'h000000, 1, 16'h7433},  // pressure before any temperature
		'{OP_PRESS, 24'h7FFFFF, 1, 16'h7433},
		'{OP_PRESS, 24'h800000, 1, 16'h7433},
		'{OP_TEMP,  24'h7FFFFF, 1, 16'h0000},
		'{OP_TEMP,  24'h800000, 1, 16'h0000},
		'{OP_PRESS, 24'h123456, 1, 16'h7433}
	};
	stim_row_t extreme_rows[] = '{
		'{OP_PRESS, 24'h7FFFFF, 0, 16'h0},
		'{OP_TEMP,  24'h7FFFFF, 0, 16'h0},
		'{OP_PRESS, 24'h7FFFFF, 0, 16'h0},
		'{OP_PRESS, 24'h800000, 0, 16'h0},
		'{OP_TEMP,  24'h800000, 0, 16'h0},
		'{OP_PRESS, 24'h800000, 0, 16'h0},
		'{OP_PRESS, 24'hFFFFFF, 0, 16'h0},
		'{OP_TEMP,  24'h000001, 0, 16'h0},
		'{OP_PRESS, 24'h000000, 0, 16'h0},
		'{OP_TEMP,  24'h000000, 0, 16'h0}
	};

	initial begin
		logic [47:0] words[3];
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cal_a = '0; cal_b = '0; cal_c = '0;
		t_osr = '0; p_osr = '0; held_temp = '0;
		no_idle = 1'b0; hold_req = 1'b0;
		mismatches = 0; temp_results = 0; press_results = 0; cfg_writes = 0; cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: temperature reads zero, pressure reads minus the reference
		foreach (reset_rows[i])
			offer_item(reset_rows[i].op, reset_rows[i].raw, 1, reset_rows[i].value);
		drain();

		// Extreme calibration against extreme readings, at the largest temperature divisor, then the smallest divisors
		for (int pass = 0; pass < 2; pass++) begin
			write_reg(REG_COEF_A, pass ? 48'h800800800008 : '1);
			write_reg(REG_COEF_B, pass ? 48'h000080008000 : 48'hFFFF7FFF7FFF);
			write_reg(REG_COEF_C, pass ? 48'h800080008000 : 48'h7FFF7FFF7FFF);
			write_reg(REG_TEMP_OSR,  pass ? 48'h000000000004 : 48'hFFFFFFFFFFFB);
			write_reg(REG_PRESS_OSR, pass ? 48'hABCDEF000004 : 48'h000000000000);
			write_reg(3'd5, '1);   // unused indexes must be dropped
			write_reg(3'd7, '0);
			cfg_valid <= 1'b0;
			foreach (extreme_rows[i])
				offer_item(extreme_rows[i].op, extreme_rows[i].raw, 0, '0);
			drain();
		end

		// Random phases with fresh calibration; one run without idling, one with a long hold
		for (int ph = 0; ph < 6; ph++) begin
			foreach (words[w]) words[w] = pick_word();
			write_reg(REG_COEF_A, words[0]);
			write_reg(REG_COEF_B, words[1]);
			write_reg(REG_COEF_C, words[2]);
			write_reg(REG_TEMP_OSR,  (ph == 0) ? 48'd0 : (ph == 1) ? 48'd7 : pick_word());
			write_reg(REG_PRESS_OSR, (ph == 0) ? 48'd7 : (ph == 1) ? 48'd0 : pick_word());
			if ($urandom_range(1)) write_reg(3'($urandom_range(5, 7)), pick_word());
			cfg_valid <= 1'b0;
			no_idle = (ph == 2);
			for (int n = 0; n < 62; n++) begin
				if (ph == 3 && n == 5) hold_req = 1'b1;
				offer_item(1'($urandom), pick_raw(), 0, '0);
			end
			drain();
			no_idle = 1'b0;
		end

		$display("covered %0d temperature and %0d pressure results over %0d register writes",
			temp_results, press_results, cfg_writes);
		$display("calibration from reset through extremes and random words, %0d cycles",
			cycles);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				pending_results.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bsc_pkg.sv
design/bsc_muldiv.sv
design/baro_sensor_compensation_core.sv
tb/sv/baro_sensor_compensation_core_test.sv
